// File: src/sha256_byte_stream_hasher_assert.svh
// assertion macros for the byte stream hasher checker
// no dependencies; included by the checker file only
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SBSH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbsh check failed");

// next-cycle implication
`define SBSH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbsh check failed");

`endif

// File: src/sbsh_pkg.sv
// shared types, constants and round functions for the sha-256 byte hasher
// no dependencies
`timescale 1ns / 1ps

package sbsh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_IDX  = 3'd7;

    function automatic t_word rotr(input t_word x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic t_word bsig0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: src/sha256_byte_stream_hasher.sv
// channel  dir  beat fields                              handshake
// input    in   data_byte, byte_present, end_of_message  i_in_valid / o_in_ready
// output   out  digest_word, word_index, last_word       o_out_valid / i_out_ready
//
// a byte beat is taken whenever input is ready; the beat that fills a 64-byte block starts
// the compression (rounds through the single round unit, then one chaining add)
// end of message: padding goes in one byte per cycle, followed by one or two
// compressions, then eight output beats; input is not ready in that time
// synchronous active-low reset loads the initial hash and empties the block
// a stalled output beat holds its word until taken
// depends on sbsh_pkg
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sbsh_pkg::*;

    t_state       r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_cnt, n_cnt;
    logic [511:0] r_blk, n_blk;
    t_word        r_h [8];
    t_word        n_h [8];
    t_word        r_v [8];
    t_word        n_v [8];
    logic [5:0]   r_rnd, n_rnd;
    logic [2:0]   r_oidx, n_oidx;
    logic         r_sent80, n_sent80;
    logic         r_len_ok, n_len_ok;
    logic         r_then_pad, n_then_pad;
    logic         r_then_out, n_then_out;

    logic         w_in_acc;
    logic [63:0]  w_bits;
    logic [7:0]   w_len_byte;
    logic [7:0]   w_pad_byte;
    t_word        w_w0, w_w1, w_w9, w_w14, w_new_w;
    t_word        w_t1, w_t2, w_ch, w_maj;

    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_bits     = {r_cnt, 3'b000};
    assign w_len_byte = w_bits[{~r_fill[2:0], 3'b000} +: 8];

    always_comb begin
        priority if (!r_sent80) begin
            w_pad_byte = PAD_MARK;
        end else if (r_len_ok && (r_fill >= LEN_START)) begin
            w_pad_byte = w_len_byte;
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // message schedule window and round unit
    assign w_w0    = r_blk[511:480];
    assign w_w1    = r_blk[479:448];
    assign w_w9    = r_blk[223:192];
    assign w_w14   = r_blk[63:32];
    assign w_new_w = w_w0 + ssig0(w_w1) + w_w9 + ssig1(w_w14);
    assign w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1    = r_v[7] + bsig1(r_v[4]) + w_ch + ROUND_K[r_rnd] + w_w0;
    assign w_t2    = bsig0(r_v[0]) + w_maj;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_byte_present && (r_fill == LAST_SLOT)) begin
                        n_state = ST_COMP;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == LAST_SLOT) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_rnd == LAST_RND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (r_then_out) begin
                    n_state = ST_OUT;
                end else if (r_then_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_ready && (r_oidx == LAST_IDX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_fill     = r_fill;
        n_cnt      = r_cnt;
        n_blk      = r_blk;
        n_h        = r_h;
        n_v        = r_v;
        n_rnd      = r_rnd;
        n_oidx     = r_oidx;
        n_sent80   = r_sent80;
        n_len_ok   = r_len_ok;
        n_then_pad = r_then_pad;
        n_then_out = r_then_out;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_byte_present) begin
                    n_blk = {r_blk[503:0], i_data_byte};
                    n_fill = r_fill + 6'd1;
                    n_cnt = r_cnt + 61'd1;
                    if (r_fill == LAST_SLOT) begin
                        n_v = r_h;
                        n_rnd = '0;
                        n_then_pad = i_end_of_message;
                        n_then_out = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                n_blk = {r_blk[503:0], w_pad_byte};
                n_fill = r_fill + 6'd1;
                if (!r_sent80) begin
                    n_sent80 = 1'b1;
                    n_len_ok = (r_fill < LEN_START);
                end
                if (r_fill == LAST_SLOT) begin
                    n_v = r_h;
                    n_rnd = '0;
                    n_then_pad = 1'b1;
                    n_then_out = r_sent80 & r_len_ok;
                end
            end
            ST_COMP: begin
                n_blk = {r_blk[479:0], w_new_w};
                n_rnd = r_rnd + 6'd1;
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + w_t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = w_t1 + w_t2;
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_len_ok = r_len_ok | r_sent80;
                n_oidx = '0;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == LAST_IDX) begin
                        n_h = INIT_H;
                        n_fill = '0;
                        n_cnt = '0;
                        n_sent80 = 1'b0;
                        n_len_ok = 1'b0;
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    // port outputs
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_out_valid   = (r_state == ST_OUT);
        o_digest_word = r_h[r_oidx];
        o_word_index  = r_oidx;
        o_last_word   = (r_oidx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_cnt      <= '0;
            r_h        <= INIT_H;
            r_oidx     <= '0;
            r_sent80   <= 1'b0;
            r_len_ok   <= 1'b0;
            r_then_pad <= 1'b0;
            r_then_out <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_cnt      <= n_cnt;
            r_h        <= n_h;
            r_oidx     <= n_oidx;
            r_sent80   <= n_sent80;
            r_len_ok   <= n_len_ok;
            r_then_pad <= n_then_pad;
            r_then_out <= n_then_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_v   <= n_v;
        r_rnd <= n_rnd;
    end

endmodule

// File: src/sbsh_checker.sv
// port-level checks for the byte stream hasher, bound to the top level
// depends on sha256_byte_stream_hasher_assert.svh
`timescale 1ns / 1ps

`include "sha256_byte_stream_hasher_assert.svh"

module sbsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_byte_present,
    input logic        i_end_of_message,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    `SBSH_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `SBSH_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, o_out_valid, o_last_word == (o_word_index == 3'd7))
    `SBSH_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_digest_word) && $stable(o_word_index))
    `SBSH_ASSERT_NXT(a_word_order, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_word, o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
    `SBSH_ASSERT_NXT(a_back_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_word, o_in_ready && !o_out_valid)

endmodule

bind sha256_byte_stream_hasher sbsh_checker u_sbsh_checker (.*);

// File: tb/testbench.sv
// self-checking testbench for sha256_byte_stream_hasher: byte beats in, digest words out
// a scoreboard class hashes each accepted beat and checks every digest word in order
// depends on the hasher rtl only
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_BEATS = 100;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam int         LEN_SLOT  = 56;
    localparam int         BLOCK_LEN = 64;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } t_digest_beat;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        int           fill;
        logic [60:0]  byte_count;
        t_digest_beat pending_words [$];
        int           errors;
        int           messages;
        int           two_block_pads;
        int           longest;
        int           bytes_hashed;
        int           words_checked;

        function new();
            errors         = 0;
            messages       = 0;
            two_block_pads = 0;
            longest        = 0;
            bytes_hashed   = 0;
            words_checked  = 0;
            foreach (blk[i]) blk[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            chain      = IV;
            fill       = 0;
            byte_count = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int s);
            return (x >> s) | (x << (32 - s));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] a;
            logic [31:0] e;
            logic [31:0] s0;
            logic [31:0] s1;
            logic [31:0] t1;
            logic [31:0] t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                s0   = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1   = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = chain;
            for (int i = 0; i < 64; i++) begin
                a  = v[0];
                e  = v[4];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                     + ((e & v[5]) ^ (~e & v[6])) + RK[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                     + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = e;
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = a;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void note_beat(logic [7:0] data, logic present, logic eom);
            logic [63:0]  bit_len;
            t_digest_beat beat;
            if (present) begin
                blk[fill]  = data;
                fill++;
                byte_count = byte_count + 61'd1;
                bytes_hashed++;
                if (fill == BLOCK_LEN) begin
                    compress();
                    fill = 0;
                end
            end
            if (!eom)
                return;
            bit_len = {byte_count, 3'b000};
            if (int'(byte_count) > longest)
                longest = int'(byte_count);
            blk[fill] = PAD_BYTE;
            fill++;
            if (fill > LEN_SLOT) begin
                while (fill < BLOCK_LEN) begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
                two_block_pads++;
            end
            while (fill < LEN_SLOT) begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (int i = 0; i < 8; i++)
                blk[LEN_SLOT + i] = bit_len[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                beat.word    = chain[i];
                beat.idx     = 3'(i);
                beat.is_last = (i == 7);
                pending_words.push_back(beat);
            end
            messages++;
            restart();
        endfunction

        function void check_beat(logic [31:0] word, logic [2:0] idx, logic is_last);
            t_digest_beat want;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected digest beat word=%h idx=%0d last=%b",
                         $time, word, idx, is_last);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (word !== want.word) begin
                $display("%0t: digest_word mismatch expected %h actual %h",
                         $time, want.word, word);
                errors++;
            end
            if (idx !== want.idx) begin
                $display("%0t: word_index mismatch expected %0d actual %0d",
                         $time, want.idx, idx);
                errors++;
            end
            if (is_last !== want.is_last) begin
                $display("%0t: last_word mismatch expected %b actual %b",
                         $time, want.is_last, is_last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard sb;
    int  beats_in;
    int  random_beats;
    int  cycles;
    bit  send_calm;
    bit  recv_calm;
    bit  hold_done;
    int  stall_left;

    sha256_byte_stream_hasher DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_digest_word    (digest_word),
        .o_word_index     (word_index),
        .o_last_word      (last_word)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic [7:0] data, input logic present, input logic eom);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= data;
        byte_present   <= present;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_beat(data, present, eom);
        beats_in++;
    endtask

    task automatic send_message(input int len, input bit trailing_eom);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && !trailing_eom);
        end
        if (len == 0 || trailing_eom)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random stalls, one long hold-off once traffic is flowing
    initial begin
        out_ready  <= 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        recv_calm  = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_beat(digest_word, word_index, last_word);
            if ($urandom_range(0, 63) == 0)
                recv_calm = !recv_calm;
            if (!hold_done && beats_in >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                stall_left = pick_gap(recv_calm);
                out_ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

    initial begin
        int  len;
        bit  trailing;
        sb             = new();
        beats_in       = 0;
        send_calm      = 1'b0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= 8'h00;
        byte_present   <= 1'b0;
        end_of_message <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle beat, empty message, single-byte extremes, short message, idle beat mid-message, two-byte message
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);

        // random messages, mostly short, some around the padding boundaries
        random_beats = beats_in;
        while (beats_in - random_beats < RANDOM_BEATS) begin
            send_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                len = $urandom_range(54, 66);
            else
                len = $urandom_range(0, 12);
            trailing = $urandom_range(0, 1);
            send_message(len, trailing);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d messages, %0d bytes, longest %0d bytes, %0d with two padded blocks",
                 sb.messages, sb.bytes_hashed, sb.longest, sb.two_block_pads);
        $display("checked %0d digest words with %0d errors", sb.words_checked, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
